FILE: hw/rtl/rrcf_pkg.sv
// Shared constants, types and coefficient table for the ADC conditioning RRC FIR.
`timescale 1ns / 1ps

package rrcf_pkg;

    localparam int TAPS    = 42;
    localparam int HIST_D  = TAPS - 1;
    localparam int HIST_AW = (HIST_D > 1) ? $clog2(HIST_D) : 1;
    localparam int TAP_W   = $clog2(TAPS);

    localparam int SAMPLE_W = 12;
    localparam int DATA_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IW   = 2;
    localparam int ACC_W    = 32;
    localparam int OPA_W    = 17;
    localparam int PROD_W   = OPA_W + DATA_W;

    localparam logic [CFG_IW-1:0] CFG_BIAS    = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_RX_GAIN = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_OVF_DET = 2'd2;

    localparam logic [SAMPLE_W-1:0]      BIAS_RST    = 12'd2048;
    localparam logic signed [DATA_W-1:0] RX_GAIN_RST = 16'sd16384;
    localparam logic [SAMPLE_W-1:0]      RAIL_HI     = 12'd4095;
    localparam logic [SAMPLE_W-1:0]      RAIL_LO     = 12'd0;

    typedef struct packed {
        logic en;
        logic clr;
    } t_mac_ctl;

    // RRC taps, alpha 0.2, 5 samples per symbol; beyond the table the taps are zero
    function automatic logic signed [DATA_W-1:0] coef(input int unsigned k);
        logic signed [DATA_W-1:0] c;
        case (k)
            0:       c = 16'sd401;
            1:       c = 16'sd104;
            2:       c = -16'sd340;
            3:       c = -16'sd731;
            4:       c = -16'sd847;
            5:       c = -16'sd553;
            6:       c = 16'sd112;
            7:       c = 16'sd909;
            8:       c = 16'sd1472;
            9:       c = 16'sd1450;
            10:      c = 16'sd683;
            11:      c = -16'sd675;
            12:      c = -16'sd2144;
            13:      c = -16'sd3040;
            14:      c = -16'sd2706;
            15:      c = -16'sd770;
            16:      c = 16'sd2667;
            17:      c = 16'sd6995;
            18:      c = 16'sd11237;
            19:      c = 16'sd14331;
            20:      c = 16'sd15464;
            21:      c = 16'sd14331;
            22:      c = 16'sd11237;
            23:      c = 16'sd6995;
            24:      c = 16'sd2667;
            25:      c = -16'sd770;
            26:      c = -16'sd2706;
            27:      c = -16'sd3040;
            28:      c = -16'sd2144;
            29:      c = -16'sd675;
            30:      c = 16'sd683;
            31:      c = 16'sd1450;
            32:      c = 16'sd1472;
            33:      c = 16'sd909;
            34:      c = 16'sd112;
            35:      c = -16'sd553;
            36:      c = -16'sd847;
            37:      c = -16'sd731;
            38:      c = -16'sd340;
            39:      c = 16'sd104;
            40:      c = 16'sd401;
            default: c = 16'sd0;
        endcase
        return c;
    endfunction

    // saturate an 18-bit signed value to 16 bits
    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [17:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 18'sd32767) begin
            r = 16'sd32767;
        end else if (v < -18'sd32768) begin
            r = -16'sd32768;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/rrcf_mac.sv
// Shared multiply-accumulate unit: registered product, then 32-bit wrapping accumulator.
`timescale 1ns / 1ps

module rrcf_mac import rrcf_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_ctl                 i_ctl,
    input  logic signed [OPA_W-1:0]  i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output logic signed [PROD_W-1:0] o_prod,
    output logic [ACC_W-1:0]         o_acc
);

    logic                     r_pv;
    logic                     r_clr;
    logic signed [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]         r_acc;
    logic signed [PROD_W-1:0] mult;

    assign mult = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_clr <= 1'b0;
        end else begin
            r_pv  <= i_ctl.en;
            r_clr <= i_ctl.clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prod <= mult;
        end
        if (r_pv) begin
            r_acc <= (r_clr ? '0 : r_acc) + r_prod[ACC_W-1:0];
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

FILE: hw/rtl/rrcf_hist.sv
// Sample history memory with per-entry valid bits; unwritten entries read as zero.
`timescale 1ns / 1ps

module rrcf_hist import rrcf_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [HIST_AW-1:0]       i_rd_addr,
    output logic signed [DATA_W-1:0] o_rd_data,
    input  logic                     i_wr_en,
    input  logic [HIST_AW-1:0]       i_wr_addr,
    input  logic signed [DATA_W-1:0] i_wr_data
);

    logic signed [DATA_W-1:0] r_mem [HIST_D];
    logic [HIST_D-1:0]        r_vld;
    logic signed [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_vld[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/adc_condition_rrc_fir.sv
// ADC conditioning (offset, gain, rail detect) and RRC FIR on one shared MAC.
// Flow: the input transfer is followed by S_GAIN, S_GWAIT, S_TAPS (one MAC step
// per tap), S_DR1 and S_DR2, which waits until the output register is free; o_valid
// then rises. o_stall is high outside S_IDLE, so no new sample is taken meanwhile.
// Reset (synchronous, active low) zeroes the sample history, restores the
// register defaults and empties the output register.
`timescale 1ns / 1ps

module adc_condition_rrc_fir import rrcf_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IW-1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [SAMPLE_W-1:0]      i_adc_sample,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_filtered,
    output logic                     o_adc_overflow
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAIN,
        S_GWAIT,
        S_TAPS,
        S_DR1,
        S_DR2
    } t_state;

    t_state                    r_state;
    logic [SAMPLE_W-1:0]       r_bias;
    logic signed [DATA_W-1:0]  r_rx_gain;
    logic                      r_ovf_det;
    logic signed [SAMPLE_W:0]  r_centered;
    logic                      r_ovf;
    logic signed [DATA_W-1:0]  r_x;
    logic [TAP_W-1:0]          r_k;
    logic [HIST_AW-1:0]        r_wp;
    logic [HIST_AW-1:0]        r_ra;
    logic                      r_o_valid;
    logic signed [DATA_W-1:0]  r_o_filtered;
    logic                      r_o_ovf;

    t_mac_ctl                  mac_ctl;
    logic signed [OPA_W-1:0]   mac_a;
    logic signed [DATA_W-1:0]  mac_b;
    logic signed [PROD_W-1:0]  mac_prod;
    logic [ACC_W-1:0]          mac_acc;
    logic signed [DATA_W-1:0]  hist_rd;
    logic signed [DATA_W-1:0]  tap_coef;
    logic                      last_tap;
    logic                      in_xfer;
    logic                      out_free;

    assign o_stall  = (r_state != S_IDLE);
    assign in_xfer  = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;
    assign last_tap = (r_k == TAP_W'(TAPS - 1));
    assign tap_coef = coef(int'(r_k));

    always_comb begin
        mac_ctl.en  = (r_state == S_GAIN) || (r_state == S_TAPS);
        mac_ctl.clr = (r_state == S_TAPS) && (r_k == '0);
        if (r_state == S_TAPS) begin
            mac_a = {tap_coef[DATA_W-1], tap_coef};
            mac_b = (r_k == '0) ? r_x : hist_rd;
        end else begin
            mac_a = {{(OPA_W-SAMPLE_W-1){r_centered[SAMPLE_W]}}, r_centered};
            mac_b = r_rx_gain;
        end
    end

    rrcf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_prod  (mac_prod),
        .o_acc   (mac_acc)
    );

    // tap k reads x[n-k], its read issued in the previous tap; new sample written after the last read
    rrcf_hist u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   ((r_state == S_TAPS) && !last_tap),
        .i_rd_addr (r_ra),
        .o_rd_data (hist_rd),
        .i_wr_en   (r_state == S_DR1),
        .i_wr_addr (r_wp),
        .i_wr_data (r_x)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias    <= BIAS_RST;
            r_rx_gain <= RX_GAIN_RST;
            r_ovf_det <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BIAS:    r_bias    <= i_cfg_data[SAMPLE_W-1:0];
                CFG_RX_GAIN: r_rx_gain <= i_cfg_data;
                CFG_OVF_DET: r_ovf_det <= i_cfg_data[0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wp      <= '0;
            r_k       <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // in S_DR2 the output register is reloaded instead
            if (r_o_valid && !i_stall && (r_state != S_DR2)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_centered <= $signed({1'b0, i_adc_sample})
                                    - $signed({1'b0, r_bias});
                        r_ovf      <= r_ovf_det &&
                                      ((i_adc_sample == RAIL_LO) || (i_adc_sample == RAIL_HI));
                        r_state    <= S_GAIN;
                    end
                end
                S_GAIN: begin
                    r_state <= S_GWAIT;
                end
                S_GWAIT: begin
                    // floor shift by 15 is the top bits of the product
                    r_x     <= sat16(mac_prod[PROD_W-1:15]);
                    r_ra    <= (r_wp == '0) ? HIST_AW'(HIST_D - 1) : r_wp - 1'b1;
                    r_k     <= '0;
                    r_state <= S_TAPS;
                end
                S_TAPS: begin
                    r_ra <= (r_ra == '0) ? HIST_AW'(HIST_D - 1) : r_ra - 1'b1;
                    r_k  <= r_k + 1'b1;
                    if (last_tap) begin
                        r_state <= S_DR1;
                    end
                end
                S_DR1: begin
                    r_wp    <= (r_wp == HIST_AW'(HIST_D - 1)) ? '0 : r_wp + 1'b1;
                    r_state <= S_DR2;
                end
                S_DR2: begin
                    if (out_free) begin
                        r_o_valid    <= 1'b1;
                        r_o_filtered <= sat16({mac_acc[ACC_W-1], mac_acc[ACC_W-1:15]});
                        r_o_ovf      <= r_ovf;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_o_valid;
    assign o_filtered     = r_o_filtered;
    assign o_adc_overflow = r_o_ovf;

endmodule
